// ===== hw/rtl/pss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the plucked-string voice modules.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int DELAY_W     = 10;
  localparam int DELAY_CNT_W = $clog2(DELAY_W);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // radix-4 serial multiplier
  localparam int MUL_DIGIT_W = 2;
  localparam int MUL_STEPS   = COEF_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int MUL_ACC_W   = SAMPLE_W + 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DECAY    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_GAIN     = 2'd3;

  // register reset values
  localparam logic [DELAY_W-1:0] RST_DELAY_SAMPLES = 10'd100;
  localparam logic [COEF_W-1:0]  RST_DECAY_FACTOR  = 16'd64880;
  localparam logic [COEF_W-1:0]  RST_GAIN_DECAY    = 16'd1;
  localparam logic [COEF_W-1:0]  RST_PEAK_GAIN     = 16'd65535;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_LOAD,
    ST_MUL,
    ST_RAW,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
  } mul_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pss_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_if
// Valid/ready channels of the plucked-string voice: input and output.
// ----------------------------------------------------------------------------
interface pss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pss_pkg::SAMPLE_W-1:0] noise_sample;
  logic                                pluck;

  modport source (output valid, output noise_sample, output pluck, input ready);
  modport sink   (input valid, input noise_sample, input pluck, output ready);
endinterface

interface pss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pss_pkg::SAMPLE_W-1:0] audio_sample;

  modport source (output valid, output audio_sample, input ready);
  modport sink   (input valid, input audio_sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pss_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_mul
// Radix-4 serial multiplier: signed Q1.15 times unsigned Q0.16, floor of the
// product shifted right by 16. Two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module pss_mul (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pss_pkg::mul_cmd_t                   cmd_i,
  input  wire logic signed [pss_pkg::SAMPLE_W-1:0] mcand_i,
  input  wire logic [pss_pkg::COEF_W-1:0]          mplier_i,
  output      pss_pkg::mul_sts_t                   sts_o,
  output      logic signed [pss_pkg::SAMPLE_W-1:0] prod_o
);

  localparam int MW = pss_pkg::SAMPLE_W + 2;

  logic signed [pss_pkg::MUL_ACC_W-1:0] acc_q, acc_d, sum;
  logic signed [MW-1:0]                 mc_q, mc3_q, addend;
  logic [pss_pkg::COEF_W-1:0]           mr_q, mr_d;
  logic [pss_pkg::MUL_CNT_W-1:0]        cnt_q, cnt_d;
  logic                                 busy_q, busy_d;
  logic                                 last;

  assign last = busy_q && (cnt_q == pss_pkg::MUL_CNT_W'(pss_pkg::MUL_STEPS - 1));

  always_comb begin
    case (mr_q[pss_pkg::MUL_DIGIT_W-1:0])
      2'd0:    addend = '0;
      2'd1:    addend = mc_q;
      2'd2:    addend = mc_q <<< 1;
      default: addend = mc3_q;
    endcase
    sum = acc_q + pss_pkg::MUL_ACC_W'(addend);
  end

  always_comb begin
    acc_d  = acc_q;
    mr_d   = mr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.load) begin
      acc_d  = '0;
      mr_d   = mplier_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d  = sum >>> pss_pkg::MUL_DIGIT_W;
      mr_d   = mr_q >> pss_pkg::MUL_DIGIT_W;
      cnt_d  = cnt_q + 1'b1;
      busy_d = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mr_q  <= mr_d;
    if (cmd_i.load) begin
      mc_q  <= MW'(mcand_i);
      mc3_q <= MW'(mcand_i) + (MW'(mcand_i) <<< 1);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = last;
  assign prod_o     = acc_q[pss_pkg::SAMPLE_W-1:0];

`ifndef ASSERT_OFF
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_o.done && !cmd_i.load) |=> !busy_q)
    else $error("multiplier still busy after last step");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/plucked_string_synth_voice_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plucked_string_synth_voice_top
// Karplus-Strong plucked-string voice with linear gain envelope.
// ----------------------------------------------------------------------------
// One noise sample in, one audio sample out. After reset the block clears
// every delay-line entry, with input ready low. Each sample then passes from
// the input transaction to the output register through a bit-serial
// reduction of delay_samples modulo the line depth, one memory read state,
// two radix-4 multiplies (feedback and envelope) on one shared serial
// multiplier with one load state each, one update state and one output state
// that holds until the output register is free. Input ready is high only in
// the idle state. The next input is taken while a finished sample still waits
// in the output register.
module plucked_string_synth_voice_top #(
  parameter int DELAY_DEPTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  pss_in_if.sink                                 in_if,
  pss_out_if.source                              out_if,
  input  wire logic                              cfg_we_i,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = pss_pkg::SAMPLE_W;
  localparam int CW = pss_pkg::COEF_W;
  localparam int DW = pss_pkg::DELAY_W;

  pss_pkg::state_e state_q, state_d;

  logic [DW-1:0]        delay_q;
  logic [CW-1:0]        decay_q, gdec_q, peak_q;
  logic signed [SW-1:0] noise_q, noise_d;
  logic [CW-1:0]        g_q, g_d, env_q, env_d;
  logic signed [SW-1:0] prev_q, prev_d, raw_q, raw_d;
  logic [AW-1:0]        wi_q, wi_d, rem_q, rem_d, clr_q, clr_d;
  logic [DW-1:0]        dsr_q, dsr_d;
  logic [pss_pkg::DELAY_CNT_W-1:0] bcnt_q, bcnt_d;
  logic                 phase_q, phase_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_data_q, out_data_d;

  logic                 in_acc;
  logic [AW:0]          rem_shift, ri_diff;
  logic [AW-1:0]        ri;
  logic signed [SW:0]   raw_sum, avg_sum;
  logic signed [SW-1:0] raw_sat;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SW-1:0]        ram_wdata, ram_rdata;

  pss_pkg::mul_cmd_t    mul_cmd;
  pss_pkg::mul_sts_t    mul_sts;
  logic signed [SW-1:0] mul_mcand, prod;
  logic [CW-1:0]        mul_mplier;

  assign in_if.ready    = (state_q == pss_pkg::ST_IDLE);
  assign in_acc         = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.audio_sample = out_data_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= pss_pkg::RST_DELAY_SAMPLES;
      decay_q <= pss_pkg::RST_DECAY_FACTOR;
      gdec_q  <= pss_pkg::RST_GAIN_DECAY;
      peak_q  <= pss_pkg::RST_PEAK_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pss_pkg::REG_DELAY_SAMPLES: delay_q <= cfg_data_i[DW-1:0];
        pss_pkg::REG_DECAY_FACTOR:  decay_q <= cfg_data_i[CW-1:0];
        pss_pkg::REG_GAIN_DECAY:    gdec_q  <= cfg_data_i[CW-1:0];
        pss_pkg::REG_PEAK_GAIN:     peak_q  <= cfg_data_i[CW-1:0];
      endcase
    end
  end

  // datapath helpers
  always_comb begin
    rem_shift = {rem_q, dsr_q[DW-1]};
    ri_diff   = {1'b0, wi_q} - {1'b0, rem_q};
    if (ri_diff[AW]) begin
      ri = AW'(ri_diff + (AW+1)'(DELAY_DEPTH));
    end else begin
      ri = ri_diff[AW-1:0];
    end
    raw_sum = {noise_q[SW-1], noise_q} + {prod[SW-1], prod};
    if (raw_sum[SW] != raw_sum[SW-1]) begin
      raw_sat = raw_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      raw_sat = raw_sum[SW-1:0];
    end
    avg_sum = {raw_sat[SW-1], raw_sat} + {prev_q[SW-1], prev_q};
  end

  // control
  always_comb begin
    state_d     = state_q;
    noise_d     = noise_q;
    g_d         = g_q;
    env_d       = env_q;
    prev_d      = prev_q;
    raw_d       = raw_q;
    wi_d        = wi_q;
    rem_d       = rem_q;
    clr_d       = clr_q;
    dsr_d       = dsr_q;
    bcnt_d      = bcnt_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = wi_q;
    ram_wdata   = avg_sum[SW:1];
    mul_cmd     = '0;
    mul_mcand   = phase_q ? raw_q : signed'(ram_rdata);
    mul_mplier  = phase_q ? g_q : decay_q;

    unique case (state_q)
      pss_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DELAY_DEPTH - 1)) begin
          state_d = pss_pkg::ST_IDLE;
        end
      end
      pss_pkg::ST_IDLE: begin
        if (in_acc) begin
          noise_d = in_if.noise_sample;
          g_d     = in_if.pluck ? peak_q : env_q;
          dsr_d   = delay_q;
          rem_d   = '0;
          bcnt_d  = pss_pkg::DELAY_CNT_W'(DW - 1);
          phase_d = 1'b0;
          state_d = pss_pkg::ST_MOD;
        end
      end
      pss_pkg::ST_MOD: begin
        if (rem_shift >= (AW+1)'(DELAY_DEPTH)) begin
          rem_d = AW'(rem_shift - (AW+1)'(DELAY_DEPTH));
        end else begin
          rem_d = rem_shift[AW-1:0];
        end
        dsr_d  = dsr_q << 1;
        bcnt_d = bcnt_q - 1'b1;
        if (bcnt_q == '0) begin
          state_d = pss_pkg::ST_RD;
        end
      end
      pss_pkg::ST_RD: begin
        state_d = pss_pkg::ST_LOAD;
      end
      pss_pkg::ST_LOAD: begin
        mul_cmd.load = 1'b1;
        state_d      = pss_pkg::ST_MUL;
      end
      pss_pkg::ST_MUL: begin
        if (mul_sts.done) begin
          state_d = phase_q ? pss_pkg::ST_FIN : pss_pkg::ST_RAW;
        end
      end
      pss_pkg::ST_RAW: begin
        ram_we  = 1'b1;
        raw_d   = raw_sat;
        prev_d  = raw_sat;
        wi_d    = (wi_q == AW'(DELAY_DEPTH - 1)) ? '0 : wi_q + 1'b1;
        env_d   = (g_q > gdec_q) ? g_q - gdec_q : '0;
        phase_d = 1'b1;
        state_d = pss_pkg::ST_LOAD;
      end
      pss_pkg::ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = prod;
          state_d     = pss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pss_pkg::ST_CLEAR;
      env_q       <= '0;
      prev_q      <= '0;
      wi_q        <= '0;
      clr_q       <= '0;
      bcnt_q      <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      env_q       <= env_d;
      prev_q      <= prev_d;
      wi_q        <= wi_d;
      clr_q       <= clr_d;
      bcnt_q      <= bcnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    noise_q    <= noise_d;
    g_q        <= g_d;
    raw_q      <= raw_d;
    rem_q      <= rem_d;
    dsr_q      <= dsr_d;
    out_data_q <= out_data_d;
  end

  pss_ram #(
    .WIDTH (SW),
    .DEPTH (DELAY_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ri),
    .rdata_o (ram_rdata)
  );

  pss_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mul_cmd),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .sts_o    (mul_sts),
    .prod_o   (prod)
  );

`ifndef ASSERT_OFF
  a_busy_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.busy |-> (state_q == pss_pkg::ST_MUL))
    else $error("multiplier busy outside multiply state");

  a_accept_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == pss_pkg::ST_MOD))
    else $error("accepted transaction did not start reduction");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pss_pkg::ST_FIN))
    else $error("output raised outside finish state");

  a_env_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pss_pkg::ST_RAW) |=> (env_q <= $past(g_q)))
    else $error("envelope increased on decay step");
`endif

endmodule
`default_nettype wire
